>>> design/hpf_pkg.sv
// Shared widths, constants, types and arithmetic steps for the head pose pipeline.
package hpf_pkg;

  localparam int COORD_BITS = 12;
  localparam int DW         = COORD_BITS + 1;
  localparam int MW         = COORD_BITS + 2;
  localparam int SW         = 2 * COORD_BITS + 4;
  localparam int AW         = 2 * COORD_BITS + 3;
  localparam int RSQW       = 2 * COORD_BITS + 1;
  localparam int GUARD      = 20;
  localparam int CW         = SW + GUARD + 2;
  localparam int ZW         = 26;
  localparam int STEPS      = 16;
  localparam int SQ_Q       = (RSQW + 8 + 1) / 2;
  localparam int SQ_VW      = 2 * SQ_Q;
  localparam int ANG_N      = (STEPS + 1 > SQ_Q) ? STEPS + 1 : SQ_Q;
  localparam int NUMW       = AW + 26;
  localparam int DENW       = AW + 14;
  localparam int QB         = 25;
  localparam int CMPW       = DENW + QB;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] BAND_LOW_RST  = CFG_W'(2253);
  localparam logic [CFG_W-1:0] BAND_HIGH_RST = CFG_W'(2540);
  localparam logic [CFG_W-1:0] GAIN_RST      = CFG_W'(717);

  localparam logic [NUMW-1:0] NUM_SCALE = NUMW'(65536000);
  localparam logic [DENW-1:0] DEN_SCALE = DENW'(8000);
  localparam logic [QB-1:0]   RATIO_MAX = QB'(1 << 24);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [DW-1:0]    dw_t;
  typedef logic signed [MW-1:0]    mw_t;
  typedef logic signed [SW-1:0]    sw_t;
  typedef logic [AW-1:0]           aw_t;
  typedef logic [RSQW-1:0]         rsq_t;
  typedef logic signed [CW-1:0]    cw_t;
  typedef logic signed [ZW-1:0]    zw_t;

  localparam zw_t DEG180 = ZW'(180 * 65536);

  typedef struct packed {
    cw_t x;
    cw_t y;
    zw_t z;
  } cord_t;

  typedef struct packed {
    logic [SQ_Q+1:0] rem;
    logic [SQ_Q-1:0] root;
  } sq_t;

  typedef struct packed {
    dw_t  c;
    dw_t  s;
    logic roll_zero;
    aw_t  yx;
    sw_t  yy;
    aw_t  n;
    aw_t  d2;
    rsq_t rsq;
  } front_t;

  typedef struct packed {
    zw_t             roll_z;
    zw_t             yaw_z;
    logic            roll_zero;
    logic            yaw_zero;
    aw_t             n;
    aw_t             d2;
    logic [SQ_Q-1:0] rq;
  } ang_t;

  typedef struct packed {
    zw_t           roll_z;
    zw_t           yaw_z;
    logic          roll_zero;
    logic          yaw_zero;
    logic [QB-1:0] ratio;
  } rat_t;

  // atan(2^-i) in 1/65536 degree
  function automatic zw_t atan_q16(input int i);
    zw_t r;
    unique case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117305);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      default: r = '0;
    endcase
    return r;
  endfunction

  // fold left half plane into right, scale up
  function automatic cord_t cordic_prep(input sw_t y, input sw_t x);
    cord_t r;
    sw_t   xa;
    sw_t   ya;
    zw_t   z0;
    xa = x;
    ya = y;
    z0 = '0;
    if (x < 0) begin
      z0 = (y >= 0) ? DEG180 : -DEG180;
      xa = -x;
      ya = -y;
    end
    r.x = cw_t'(xa) <<< GUARD;
    r.y = cw_t'(ya) <<< GUARD;
    r.z = z0;
    return r;
  endfunction

  function automatic cord_t cordic_step(input cord_t a, input int i);
    cord_t r;
    cw_t   x0;
    cw_t   y0;
    cw_t   xs;
    cw_t   ys;
    x0 = a.x;
    y0 = a.y;
    xs = y0 >>> i;
    ys = x0 >>> i;
    if (!y0[CW-1]) begin
      r.x = x0 + xs;
      r.y = y0 - ys;
      r.z = a.z + atan_q16(i);
    end else begin
      r.x = x0 - xs;
      r.y = y0 + ys;
      r.z = a.z - atan_q16(i);
    end
    return r;
  endfunction

  // one restoring square root digit
  function automatic sq_t sqrt_step(input sq_t a, input logic [1:0] d);
    sq_t             r;
    logic [SQ_Q+2:0] rs;
    logic [SQ_Q+2:0] tr;
    logic [SQ_Q+2:0] df;
    rs = {a.rem[SQ_Q:0], d};
    tr = {1'b0, a.root, 2'b01};
    df = rs - tr;
    if (rs >= tr) begin
      r.rem  = df[SQ_Q+1:0];
      r.root = {a.root[SQ_Q-2:0], 1'b1};
    end else begin
      r.rem  = rs[SQ_Q+1:0];
      r.root = {a.root[SQ_Q-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic aw_t sw_abs(input sw_t v);
    sw_t a;
    a = v[SW-1] ? -v : v;
    return a[AW-1:0];
  endfunction

endpackage

>>> design/hpf_front.sv
// Eye vector, rotation products and distance terms: four pipeline stages.
module hpf_front import hpf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  coord_t [4:0]   px,
  input  coord_t [4:0]   py,
  output logic           out_valid,
  input  logic           out_ready,
  output front_t         out_data
);

  logic [3:0] v_r;
  logic [3:0] ld;

  assign ld[3] = !v_r[3] || out_ready;
  generate
    for (genvar k = 0; k < 3; k++) begin : g_ld
      assign ld[k] = !v_r[k] || ld[k+1];
    end
  endgenerate
  assign in_ready  = ld[0];
  assign out_valid = v_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      if (ld[1]) v_r[1] <= v_r[0];
      if (ld[2]) v_r[2] <= v_r[1];
      if (ld[3]) v_r[3] <= v_r[2];
    end
  end

  // stage A: differences
  dw_t  a_c_r, a_s_r, a_cr_r, a_e20x_r, a_e20y_r, a_e12x_r, a_e12y_r;
  mw_t  a_mx_r, a_my_r;
  logic a_zero_r;
  dw_t  a_c_nxt, a_s_nxt, a_cr_nxt, a_e20x_nxt, a_e20y_nxt, a_e12x_nxt, a_e12y_nxt;
  mw_t  a_mx_nxt, a_my_nxt;
  logic a_zero_nxt;

  always_comb begin
    a_c_nxt    = $signed(DW'(px[1])) - $signed(DW'(px[0]));
    a_s_nxt    = $signed(DW'(py[1])) - $signed(DW'(py[0]));
    a_zero_nxt = (a_c_nxt == '0) && (a_s_nxt == '0);
    a_cr_nxt   = a_zero_nxt ? DW'(1) : a_c_nxt;
    a_e20x_nxt = $signed(DW'(px[2])) - $signed(DW'(px[0]));
    a_e20y_nxt = $signed(DW'(py[2])) - $signed(DW'(py[0]));
    a_e12x_nxt = $signed(DW'(px[1])) - $signed(DW'(px[2]));
    a_e12y_nxt = $signed(DW'(py[1])) - $signed(DW'(py[2]));
    a_mx_nxt   = $signed(MW'(px[3]) + MW'(px[4]) - (MW'(px[0]) << 1));
    a_my_nxt   = $signed(MW'(py[3]) + MW'(py[4]) - (MW'(py[0]) << 1));
  end

  // stage B: products
  dw_t  b_c_r, b_s_r;
  logic b_zero_r;
  sw_t  b_p_r [10];
  sw_t  b_p_nxt [10];

  always_comb begin
    b_p_nxt[0] = sw_t'(a_cr_r) * sw_t'(a_e20x_r);
    b_p_nxt[1] = sw_t'(a_s_r)  * sw_t'(a_e20y_r);
    b_p_nxt[2] = sw_t'(a_cr_r) * sw_t'(a_e12x_r);
    b_p_nxt[3] = sw_t'(a_s_r)  * sw_t'(a_e12y_r);
    b_p_nxt[4] = sw_t'(a_cr_r) * sw_t'(a_e20y_r);
    b_p_nxt[5] = sw_t'(a_s_r)  * sw_t'(a_e20x_r);
    b_p_nxt[6] = sw_t'(a_cr_r) * sw_t'(a_my_r);
    b_p_nxt[7] = sw_t'(a_s_r)  * sw_t'(a_mx_r);
    b_p_nxt[8] = sw_t'(a_cr_r) * sw_t'(a_cr_r);
    b_p_nxt[9] = sw_t'(a_s_r)  * sw_t'(a_s_r);
  end

  // stage C: rotated distances
  dw_t  c_c_r, c_s_r;
  logic c_zero_r;
  sw_t  c_l_r, c_r_r, c_n_r, c_d_r;
  rsq_t c_rsq_r;
  sw_t  c_sq_nxt;

  assign c_sq_nxt = b_p_r[8] + b_p_r[9];

  // stage D: magnitudes and yaw vector
  logic d_ov_unused;
  aw_t  d_l, d_r;
  aw_t  dd_yx_r, dd_n_r, dd_d2_r;
  sw_t  dd_yy_r;
  dw_t  dd_c_r, dd_s_r;
  logic dd_zero_r;
  rsq_t dd_rsq_r;

  assign d_l = sw_abs(c_l_r);
  assign d_r = sw_abs(c_r_r);
  assign d_ov_unused = 1'b0;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_c_r    <= a_c_nxt;
      a_s_r    <= a_s_nxt;
      a_cr_r   <= a_cr_nxt;
      a_zero_r <= a_zero_nxt;
      a_e20x_r <= a_e20x_nxt;
      a_e20y_r <= a_e20y_nxt;
      a_e12x_r <= a_e12x_nxt;
      a_e12y_r <= a_e12y_nxt;
      a_mx_r   <= a_mx_nxt;
      a_my_r   <= a_my_nxt;
    end
    if (ld[1]) begin
      b_c_r    <= a_c_r;
      b_s_r    <= a_s_r;
      b_zero_r <= a_zero_r;
      b_p_r    <= b_p_nxt;
    end
    if (ld[2]) begin
      c_c_r    <= b_c_r;
      c_s_r    <= b_s_r;
      c_zero_r <= b_zero_r;
      c_l_r    <= b_p_r[0] + b_p_r[1];
      c_r_r    <= b_p_r[2] + b_p_r[3];
      c_n_r    <= b_p_r[4] - b_p_r[5];
      c_d_r    <= b_p_r[6] - b_p_r[7];
      c_rsq_r  <= c_sq_nxt[RSQW-1:0];
    end
    if (ld[3]) begin
      dd_c_r    <= c_c_r;
      dd_s_r    <= c_s_r;
      dd_zero_r <= c_zero_r || d_ov_unused;
      dd_yx_r   <= (d_l > d_r) ? d_l : d_r;
      dd_yy_r   <= $signed({1'b0, d_r}) - $signed({1'b0, d_l});
      dd_n_r    <= sw_abs(c_n_r);
      dd_d2_r   <= sw_abs(c_d_r);
      dd_rsq_r  <= c_rsq_r;
    end
  end

  always_comb begin
    out_data.c         = dd_c_r;
    out_data.s         = dd_s_r;
    out_data.roll_zero = dd_zero_r;
    out_data.yx        = dd_yx_r;
    out_data.yy        = dd_yy_r;
    out_data.n         = dd_n_r;
    out_data.d2        = dd_d2_r;
    out_data.rsq       = dd_rsq_r;
  end

endmodule

>>> design/hpf_angle.sv
// Roll and yaw CORDIC vectoring lanes beside a digit-per-stage square root.
module hpf_angle import hpf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output ang_t   out_data
);

  typedef struct packed {
    logic             roll_zero;
    logic             yaw_zero;
    aw_t              n;
    aw_t              d2;
    logic [SQ_VW-1:0] v;
  } side_t;

  logic [ANG_N-1:0] v_r;
  logic [ANG_N-1:0] ld;
  cord_t roll_r [ANG_N];
  cord_t yaw_r  [ANG_N];
  sq_t   sq_r   [ANG_N];
  side_t sd_r   [ANG_N];
  cord_t roll_nxt [ANG_N];
  cord_t yaw_nxt  [ANG_N];
  sq_t   sq_nxt   [ANG_N];
  side_t sd_nxt   [ANG_N];

  assign ld[ANG_N-1] = !v_r[ANG_N-1] || out_ready;
  assign in_ready    = ld[0];
  assign out_valid   = v_r[ANG_N-1];

  generate
    for (genvar k = 0; k < ANG_N; k++) begin : g_st
      if (k < ANG_N - 1) begin : g_ld
        assign ld[k] = !v_r[k] || ld[k+1];
      end
      if (k == 0) begin : g_first
        always_comb begin
          roll_nxt[0]        = cordic_prep(sw_t'(in_data.s), sw_t'(in_data.c));
          yaw_nxt[0]         = cordic_prep(in_data.yy, $signed({1'b0, in_data.yx}));
          sd_nxt[0].roll_zero = in_data.roll_zero;
          sd_nxt[0].yaw_zero  = (in_data.yx == '0) && (in_data.yy == '0);
          sd_nxt[0].n         = in_data.n;
          sd_nxt[0].d2        = in_data.d2;
          sd_nxt[0].v         = SQ_VW'({in_data.rsq, 8'b0});
          sq_nxt[0]           = sqrt_step('0, sd_nxt[0].v[SQ_VW-1 -: 2]);
        end
      end else begin : g_rest
        assign sd_nxt[k] = sd_r[k-1];
        if (k <= STEPS) begin : g_cor
          assign roll_nxt[k] = cordic_step(roll_r[k-1], k - 1);
          assign yaw_nxt[k]  = cordic_step(yaw_r[k-1], k - 1);
        end else begin : g_cpass
          assign roll_nxt[k] = roll_r[k-1];
          assign yaw_nxt[k]  = yaw_r[k-1];
        end
        if (k < SQ_Q) begin : g_sq
          assign sq_nxt[k] = sqrt_step(sq_r[k-1], sd_r[k-1].v[SQ_VW-1-2*k -: 2]);
        end else begin : g_spass
          assign sq_nxt[k] = sq_r[k-1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int k = 1; k < ANG_N; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ANG_N; k++) begin
      if (ld[k]) begin
        roll_r[k] <= roll_nxt[k];
        yaw_r[k]  <= yaw_nxt[k];
        sq_r[k]   <= sq_nxt[k];
        sd_r[k]   <= sd_nxt[k];
      end
    end
  end

  always_comb begin
    out_data.roll_z    = roll_r[ANG_N-1].z;
    out_data.yaw_z     = yaw_r[ANG_N-1].z;
    out_data.roll_zero = sd_r[ANG_N-1].roll_zero;
    out_data.yaw_zero  = sd_r[ANG_N-1].yaw_zero;
    out_data.n         = sd_r[ANG_N-1].n;
    out_data.d2        = sd_r[ANG_N-1].d2;
    out_data.rq        = sq_r[ANG_N-1].root;
  end

endmodule

>>> design/hpf_ratio.sv
// Vertical distance ratio in Q.12: scaling stage, overflow test, one quotient bit per stage.
module hpf_ratio import hpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ang_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rat_t out_data
);

  localparam int RN = QB + 2;

  typedef struct packed {
    logic [NUMW-1:0] rem;
    logic [DENW-1:0] den;
    logic [QB-1:0]   q;
    logic            sat;
  } div_t;

  typedef struct packed {
    zw_t  roll_z;
    zw_t  yaw_z;
    logic roll_zero;
    logic yaw_zero;
  } angs_t;

  logic [RN-1:0] v_r;
  logic [RN-1:0] ld;
  div_t  dv_r   [RN];
  angs_t an_r   [RN];
  div_t  dv_nxt [RN];
  angs_t an_nxt [RN];

  assign ld[RN-1]  = !v_r[RN-1] || out_ready;
  assign in_ready  = ld[0];
  assign out_valid = v_r[RN-1];

  generate
    for (genvar k = 0; k < RN; k++) begin : g_st
      if (k < RN - 1) begin : g_ld
        assign ld[k] = !v_r[k] || ld[k+1];
      end
      if (k == 0) begin : g_scale
        always_comb begin
          dv_nxt[0].rem = NUMW'(in_data.n) * NUM_SCALE;
          dv_nxt[0].den = DENW'(in_data.d2) * DEN_SCALE + DENW'(in_data.rq);
          dv_nxt[0].q   = '0;
          dv_nxt[0].sat = 1'b0;
          an_nxt[0].roll_z    = in_data.roll_z;
          an_nxt[0].yaw_z     = in_data.yaw_z;
          an_nxt[0].roll_zero = in_data.roll_zero;
          an_nxt[0].yaw_zero  = in_data.yaw_zero;
        end
      end else if (k == 1) begin : g_ovf
        always_comb begin
          dv_nxt[1]     = dv_r[0];
          dv_nxt[1].sat = CMPW'(dv_r[0].rem) >= (CMPW'(dv_r[0].den) << QB);
        end
        assign an_nxt[1] = an_r[0];
      end else begin : g_bit
        localparam int B = QB + 1 - k;
        logic [CMPW-1:0] sh;
        assign sh = CMPW'(dv_r[k-1].den) << B;
        always_comb begin
          dv_nxt[k] = dv_r[k-1];
          if (!dv_r[k-1].sat && (CMPW'(dv_r[k-1].rem) >= sh)) begin
            dv_nxt[k].rem  = dv_r[k-1].rem - sh[NUMW-1:0];
            dv_nxt[k].q[B] = 1'b1;
          end
        end
        assign an_nxt[k] = an_r[k-1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int k = 1; k < RN; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RN; k++) begin
      if (ld[k]) begin
        dv_r[k] <= dv_nxt[k];
        an_r[k] <= an_nxt[k];
      end
    end
  end

  always_comb begin
    out_data.roll_z    = an_r[RN-1].roll_z;
    out_data.yaw_z     = an_r[RN-1].yaw_z;
    out_data.roll_zero = an_r[RN-1].roll_zero;
    out_data.yaw_zero  = an_r[RN-1].yaw_zero;
    out_data.ratio     = (dv_r[RN-1].sat || (dv_r[RN-1].q > RATIO_MAX)) ?
                         RATIO_MAX : dv_r[RN-1].q;
  end

endmodule

>>> design/hpf_pitch.sv
// Dead band, gain and degree scaling for pitch; centidegree rounding and limits for all angles.
module hpf_pitch import hpf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rat_t                     in_data,
  input  logic [CFG_W-1:0]         band_low,
  input  logic [CFG_W-1:0]         band_high,
  input  logic [CFG_W-1:0]         gain,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       roll_centideg,
  output logic signed [13:0]       yaw_centideg,
  output logic signed [15:0]       pitch_centideg
);

  localparam int EW   = QB + 2;
  localparam int MULW = EW + CFG_W + 1;
  localparam int TW   = 25;
  localparam int PKW  = TW + 30;
  localparam int HW   = ZW + 7;

  localparam logic signed [HW-1:0]   CENT      = HW'(100);
  localparam logic signed [HW-1:0]   HALF16    = HW'(32768);
  localparam logic signed [HW-1:0]   ROLL_LIM  = HW'(18000);
  localparam logic signed [HW-1:0]   YAW_LIM   = HW'(4500);
  localparam logic signed [MULW-1:0] T_LIM     = MULW'(1 << 23);
  localparam logic signed [PKW-1:0]  PITCH_K   = PKW'(375493621);
  localparam logic signed [PKW-1:0]  HALF36    = PKW'(64'sd1 << 35);
  localparam logic signed [PKW-1:0]  PITCH_LIM = PKW'(18000);

  logic [4:0] v_r;
  logic [4:0] ld;

  assign ld[4] = !v_r[4] || out_ready;
  generate
    for (genvar k = 0; k < 4; k++) begin : g_ld
      assign ld[k] = !v_r[k] || ld[k+1];
    end
  endgenerate
  assign in_ready  = ld[0];
  assign out_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: band excess, angles times 100
  logic signed [EW-1:0] p0_err_r, p0_err_nxt;
  logic signed [HW-1:0] p0_r100_r, p0_y100_r;
  logic                 p0_rz_r, p0_yz_r;
  logic signed [EW-1:0] rs, lo, hi;

  always_comb begin
    rs = $signed(EW'(in_data.ratio));
    lo = $signed(EW'(band_low));
    hi = $signed(EW'(band_high));
    priority if (rs < lo) p0_err_nxt = rs - lo;
    else if (rs > hi)     p0_err_nxt = rs - hi;
    else                  p0_err_nxt = '0;
  end

  // stage 1: gain product, angle rounding
  logic signed [MULW-1:0] p1_m_r;
  logic signed [15:0]     p1_roll_r, p1_roll_nxt;
  logic signed [13:0]     p1_yaw_r, p1_yaw_nxt;
  logic signed [HW-1:0]   rr, ry;

  always_comb begin
    rr = -((p0_r100_r + HALF16) >>> 16);
    ry = (p0_y100_r + HALF16) >>> 16;
    if (rr > ROLL_LIM)       rr = ROLL_LIM;
    else if (rr < -ROLL_LIM) rr = -ROLL_LIM;
    if (ry > YAW_LIM)        ry = YAW_LIM;
    else if (ry < -YAW_LIM)  ry = -YAW_LIM;
    p1_roll_nxt = p0_rz_r ? '0 : rr[15:0];
    p1_yaw_nxt  = p0_yz_r ? '0 : ry[13:0];
  end

  // stage 2: limit
  logic signed [TW-1:0] p2_t_r;
  logic signed [TW-1:0] p2_t_nxt;
  logic signed [15:0]   p2_roll_r;
  logic signed [13:0]   p2_yaw_r;

  always_comb begin
    if (p1_m_r > T_LIM)       p2_t_nxt = T_LIM[TW-1:0];
    else if (p1_m_r < -T_LIM) p2_t_nxt = TW'(-T_LIM);
    else                      p2_t_nxt = p1_m_r[TW-1:0];
  end

  // stage 3: radians to centidegrees
  logic signed [PKW-1:0] p3_pk_r;
  logic signed [15:0]    p3_roll_r;
  logic signed [13:0]    p3_yaw_r;

  // stage 4: round and limit
  logic signed [PKW-1:0] pp;
  logic signed [15:0]    p4_pitch_nxt;

  always_comb begin
    pp = (p3_pk_r + HALF36) >>> 36;
    if (pp > PITCH_LIM)       p4_pitch_nxt = PITCH_LIM[15:0];
    else if (pp < -PITCH_LIM) p4_pitch_nxt = 16'(-PITCH_LIM);
    else                      p4_pitch_nxt = pp[15:0];
  end

  logic signed [15:0] p4_roll_r, p4_pitch_r;
  logic signed [13:0] p4_yaw_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p0_err_r  <= p0_err_nxt;
      p0_r100_r <= HW'(in_data.roll_z) * CENT;
      p0_y100_r <= HW'(in_data.yaw_z) * CENT;
      p0_rz_r   <= in_data.roll_zero;
      p0_yz_r   <= in_data.yaw_zero;
    end
    if (ld[1]) begin
      p1_m_r    <= MULW'(p0_err_r) * $signed(MULW'(gain));
      p1_roll_r <= p1_roll_nxt;
      p1_yaw_r  <= p1_yaw_nxt;
    end
    if (ld[2]) begin
      p2_t_r    <= p2_t_nxt;
      p2_roll_r <= p1_roll_r;
      p2_yaw_r  <= p1_yaw_r;
    end
    if (ld[3]) begin
      p3_pk_r   <= PKW'(p2_t_r) * PITCH_K;
      p3_roll_r <= p2_roll_r;
      p3_yaw_r  <= p2_yaw_r;
    end
    if (ld[4]) begin
      p4_pitch_r <= p4_pitch_nxt;
      p4_roll_r  <= p3_roll_r;
      p4_yaw_r   <= p3_yaw_r;
    end
  end

  assign roll_centideg  = p4_roll_r;
  assign yaw_centideg   = p4_yaw_r;
  assign pitch_centideg = p4_pitch_r;

endmodule

>>> design/head_pose_from_five_landmarks.sv
// Top level: head pose (roll, yaw, pitch) from five facial landmarks.
//
//   channel  ports                          transfer
//   in       in_valid / in_ready            one landmark set per request
//   out      out_valid / out_ready          one roll, yaw, pitch triple per request
//   cfg      cfg_we, cfg_index, cfg_data    one register write per cycle, no read-back
//
// One request per cycle while the output is not stalled; pipeline stages: 4 front, 17 CORDIC and
// square root, 27 in the bit-per-stage divider, 5 pitch.
// Every stage holds its own valid bit and loads when empty or when the next one moves,
// so a stalled output only backs up as far as the first empty stage.
// Synchronous active-low reset clears valid bits and restores the three registers.
module head_pose_from_five_landmarks import hpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [11:0]          in_left_eye_x,
  input  logic [11:0]          in_left_eye_y,
  input  logic [11:0]          in_right_eye_x,
  input  logic [11:0]          in_right_eye_y,
  input  logic [11:0]          in_nose_x,
  input  logic [11:0]          in_nose_y,
  input  logic [11:0]          in_mouth_a_x,
  input  logic [11:0]          in_mouth_a_y,
  input  logic [11:0]          in_mouth_b_x,
  input  logic [11:0]          in_mouth_b_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_roll_centideg,
  output logic signed [13:0]   out_yaw_centideg,
  output logic signed [15:0]   out_pitch_centideg,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] band_low_r, band_high_r, gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= BAND_LOW_RST;
      band_high_r <= BAND_HIGH_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BAND_LOW:  band_low_r  <= cfg_data;
        CFG_BAND_HIGH: band_high_r <= cfg_data;
        CFG_GAIN:      gain_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  coord_t [4:0] px, py;

  assign px[0] = in_left_eye_x[COORD_BITS-1:0];
  assign py[0] = in_left_eye_y[COORD_BITS-1:0];
  assign px[1] = in_right_eye_x[COORD_BITS-1:0];
  assign py[1] = in_right_eye_y[COORD_BITS-1:0];
  assign px[2] = in_nose_x[COORD_BITS-1:0];
  assign py[2] = in_nose_y[COORD_BITS-1:0];
  assign px[3] = in_mouth_a_x[COORD_BITS-1:0];
  assign py[3] = in_mouth_a_y[COORD_BITS-1:0];
  assign px[4] = in_mouth_b_x[COORD_BITS-1:0];
  assign py[4] = in_mouth_b_y[COORD_BITS-1:0];

  logic   f_valid, f_ready;
  front_t f_data;
  logic   a_valid, a_ready;
  ang_t   a_data;
  logic   r_valid, r_ready;
  rat_t   r_data;

  hpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .px        (px),
    .py        (py),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  hpf_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_data  (a_data)
  );

  hpf_ratio u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_data   (a_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  hpf_pitch u_pitch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (r_valid),
    .in_ready       (r_ready),
    .in_data        (r_data),
    .band_low       (band_low_r),
    .band_high      (band_high_r),
    .gain           (gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .roll_centideg  (out_roll_centideg),
    .yaw_centideg   (out_yaw_centideg),
    .pitch_centideg (out_pitch_centideg)
  );

endmodule

>>> verif/head_pose_from_five_landmarks_tb.sv
// Testbench for the landmark head pose block: directed and random landmark sets, predicted results.
`timescale 1ns / 1ps

module head_pose_from_five_landmarks_tb;
  import hpf_pkg::*;

  typedef struct {
    logic [11:0] v [10];
  } landmarks_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [13:0] yaw;
    logic signed [15:0] pitch;
  } pose_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [11:0] in_f [10];
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_roll_centideg;
  logic signed [13:0] out_yaw_centideg;
  logic signed [15:0] out_pitch_centideg;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  head_pose_from_five_landmarks u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_left_eye_x(in_f[0]), .in_left_eye_y(in_f[1]),
    .in_right_eye_x(in_f[2]), .in_right_eye_y(in_f[3]),
    .in_nose_x(in_f[4]), .in_nose_y(in_f[5]),
    .in_mouth_a_x(in_f[6]), .in_mouth_a_y(in_f[7]),
    .in_mouth_b_x(in_f[8]), .in_mouth_b_y(in_f[9]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_centideg(out_roll_centideg), .out_yaw_centideg(out_yaw_centideg),
    .out_pitch_centideg(out_pitch_centideg),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  landmarks_t pending_sets [$];
  pose_t expected_poses [$];
  longint band_low, band_high, gain;
  int errors;
  int send_count;
  bit idle_ok;
  bit rx_hold_req;
  int rx_hold_left;
  bit in_taken;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint atan2_q16(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x = x <<< 20;
    y = y <<< 20;
    for (int i = 0; i < 16; i++) begin
      xs = sra(y, i);
      ys = sra(x, i);
      if (y >= 0) begin
        x += xs; y -= ys; z += longint'(atan_q16(i));
      end else begin
        x -= xs; y += ys; z -= longint'(atan_q16(i));
      end
    end
    return z;
  endfunction

  function automatic longint centideg(longint z);
    return sra(z * 100 + 32768, 16);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic pose_t predict_pose(landmarks_t p);
    pose_t o;
    longint px [5], py [5], xr [5], yr [5];
    longint c, s, roll, yaw, pitch, l, r, mx, n, d2, ratio, err, t, den, rq;
    for (int k = 0; k < 5; k++) begin
      px[k] = p.v[2*k];
      py[k] = p.v[2*k+1];
    end
    c = px[1] - px[0];
    s = py[1] - py[0];
    roll = clip(-centideg(atan2_q16(s, c)), 18000);
    if (c == 0 && s == 0) c = 1;
    for (int k = 0; k < 5; k++) begin
      xr[k] = c * px[k] + s * py[k];
      yr[k] = c * py[k] - s * px[k];
    end
    l = xr[2] - xr[0]; if (l < 0) l = -l;
    r = xr[1] - xr[2]; if (r < 0) r = -r;
    mx = l > r ? l : r;
    yaw = clip(centideg(atan2_q16(r - l, mx)), 4500);
    n = yr[2] - yr[0]; if (n < 0) n = -n;
    d2 = yr[3] + yr[4] - 2 * yr[0]; if (d2 < 0) d2 = -d2;
    rq = int_sqrt((c * c + s * s) <<< 8);
    den = 8000 * d2 + rq;
    ratio = (65536000 * n) / den;
    if (ratio > (64'sd1 <<< 24)) ratio = 64'sd1 <<< 24;
    err = 0;
    if (ratio < band_low) err = ratio - band_low;
    else if (ratio > band_high) err = ratio - band_high;
    t = clip(err * gain, 64'sd1 <<< 23);
    pitch = clip(sra(t * 375493621 + (64'sd1 <<< 35), 36), 18000);
    o.roll = roll[15:0];
    o.yaw = yaw[13:0];
    o.pitch = pitch[15:0];
    return o;
  endfunction

  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_taken) begin
    end else if (pending_sets.size() > 0 && (!idle_ok || $urandom_range(99) >= 10)) begin
      landmarks_t p;
      p = pending_sets.pop_front();
      for (int k = 0; k < 10; k++) in_f[k] <= p.v[k];
      expected_poses.push_back(predict_pose(p));
      in_valid <= 1;
      send_count++;
    end else begin
      in_valid <= 0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      rx_hold_left = 0;
    end else begin
      if (rx_hold_req) begin
        rx_hold_left = 300;
        rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= !idle_ok || $urandom_range(99) >= 10;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_poses.size() == 0) begin
        $error("unexpected result roll=%0d", out_roll_centideg);
        errors++;
      end else begin
        pose_t e;
        e = expected_poses.pop_front();
        if (e.roll !== out_roll_centideg) begin
          $error("roll_centideg exp %0d got %0d", e.roll, out_roll_centideg);
          errors++;
        end
        if (e.yaw !== out_yaw_centideg) begin
          $error("yaw_centideg exp %0d got %0d", e.yaw, out_yaw_centideg);
          errors++;
        end
        if (e.pitch !== out_pitch_centideg) begin
          $error("pitch_centideg exp %0d got %0d", e.pitch, out_pitch_centideg);
          errors++;
        end
      end
    end
  end

  task automatic add_set(int a0, int a1, int a2, int a3, int a4, int a5, int a6,
                         int a7, int a8, int a9);
    landmarks_t p;
    p.v[0] = 12'(a0); p.v[1] = 12'(a1); p.v[2] = 12'(a2); p.v[3] = 12'(a3);
    p.v[4] = 12'(a4); p.v[5] = 12'(a5); p.v[6] = 12'(a6); p.v[7] = 12'(a7);
    p.v[8] = 12'(a8); p.v[9] = 12'(a9);
    pending_sets.push_back(p);
  endtask

  // plausible face around a random center, or noise
  task automatic add_random_set();
    int cx, cy, w, h, tx;
    if ($urandom_range(9) < 2) begin
      landmarks_t p;
      for (int k = 0; k < 10; k++) p.v[k] = 12'($urandom_range(4095));
      pending_sets.push_back(p);
    end else begin
      w = $urandom_range(200, 1);
      h = $urandom_range(200, 1);
      cx = $urandom_range(3800, 250);
      cy = $urandom_range(3800, 250);
      tx = $urandom_range(2 * w) - w;
      add_set(cx - w, cy - $urandom_range(20), cx + w, cy - $urandom_range(20),
              cx + tx / 2, cy + $urandom_range(h), cx - w + $urandom_range(20),
              cy + h + $urandom_range(h), cx + w - $urandom_range(20),
              cy + h + $urandom_range(h));
    end
  endtask

  task automatic drain();
    while (pending_sets.size() > 0 || in_valid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    band_low = (idx == CFG_BAND_LOW) ? val : band_low;
    band_high = (idx == CFG_BAND_HIGH) ? val : band_high;
    gain = (idx == CFG_GAIN) ? val : gain;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    errors = 0;
    send_count = 0;
    idle_ok = 0;
    rx_hold_req = 0;
    rst_n = 0;
    in_valid = 0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = CFG_BAND_LOW;
    cfg_data = 0;
    for (int k = 0; k < 10; k++) in_f[k] = 0;
    band_low = 2253;
    band_high = 2540;
    gain = 717;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    add_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_set(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    add_set(0, 0, 4095, 4095, 0, 4095, 4095, 0, 0, 4095);
    add_set(4095, 0, 0, 4095, 2048, 2048, 0, 0, 4095, 4095);
    add_set(100, 100, 100, 100, 100, 150, 90, 200, 110, 200);
    add_set(100, 100, 200, 100, 150, 100, 120, 100, 180, 100);
    add_set(200, 100, 100, 100, 150, 140, 120, 200, 180, 200);
    add_set(100, 200, 100, 100, 150, 150, 200, 160, 200, 140);
    add_set(100, 100, 200, 100, 150, 4095, 140, 101, 160, 100);
    add_set(1000, 1000, 1100, 1000, 1000, 1050, 1020, 1100, 1080, 1100);
    add_set(1000, 1000, 1100, 1000, 1100, 1060, 1020, 1100, 1080, 1100);
    add_set(1000, 1000, 1100, 1000, 1050, 1055, 1020, 1100, 1080, 1100);
    add_set(1000, 1000, 1100, 1000, 1050, 1090, 1020, 1100, 1080, 1100);
    add_set(1000, 1000, 1100, 1000, 1050, 1005, 1020, 1100, 1080, 1100);
    add_set(1000, 1000, 1080, 1060, 1050, 1080, 1000, 1140, 1060, 1180);
    add_set(2730, 1365, 1365, 2730, 2730, 2730, 1365, 1365, 2730, 1365);
    drain();

    idle_ok = 1;
    for (int i = 0; i < 200; i++) add_random_set();
    drain();

    write_reg(CFG_BAND_LOW, 4095);
    write_reg(CFG_BAND_HIGH, 0);
    write_reg(CFG_GAIN, 4095);
    for (int i = 0; i < 100; i++) add_random_set();
    drain();

    write_reg(CFG_BAND_LOW, 0);
    write_reg(CFG_BAND_HIGH, 4095);
    write_reg(CFG_GAIN, 0);
    for (int i = 0; i < 50; i++) add_random_set();
    drain();

    // back-pressure: receiver stalls while the sender keeps going
    write_reg(CFG_BAND_LOW, $urandom_range(4095));
    write_reg(CFG_BAND_HIGH, $urandom_range(4095));
    write_reg(CFG_GAIN, $urandom_range(4095));
    rx_hold_req = 1;
    for (int i = 0; i < 150; i++) add_random_set();
    drain();

    write_reg(CFG_BAND_LOW, 1800);
    write_reg(CFG_BAND_HIGH, 2900);
    write_reg(CFG_GAIN, 1);
    idle_ok = 0;
    for (int i = 0; i < 100; i++) add_random_set();
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
